// ===== design/ahplc_pkg.sv =====
`default_nettype none

package ahplc_pkg;

  // default refresh interval in milliseconds
  localparam int unsigned REFRESH_MS_DEFAULT = 20;

  // configuration port
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  // holding adapts only while inside these limits
  localparam logic signed [9:0] HOLD_ADAPT_MIN = -10'sd127;
  localparam logic signed [9:0] HOLD_ADAPT_MAX = 10'sd127;

  // holding saturation after each adaptation
  localparam logic signed [10:0] HOLD_SAT_MIN = -11'sd511;
  localparam logic signed [10:0] HOLD_SAT_MAX = 11'sd511;

  // neutral learns only while inside these limits
  localparam logic signed [8:0] NEUTRAL_MIN = -9'sd127;
  localparam logic signed [8:0] NEUTRAL_MAX = 9'sd127;

  typedef enum logic [2:0] {
    REG_GAIN_P          = 3'd0,
    REG_NEUTRAL_INITIAL = 3'd1,
    REG_STEP_CHANGE     = 3'd2,
    REG_ERROR_THRESHOLD = 3'd3,
    REG_UPPER_BOUND     = 3'd4,
    REG_LOWER_BOUND     = 3'd5,
    REG_MAX_SPEED       = 3'd6,
    REG_LEARN_ENABLE    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [7:0]  neutral_initial;
    logic        [6:0]  step_change;
    logic        [14:0] error_threshold;
    logic signed [15:0] upper_bound;
    logic signed [15:0] lower_bound;
    logic        [14:0] max_speed;
    logic               learn_enable;
  } cfg_t;

  typedef struct packed {
    logic s1_fire;
    logic mid_load;
    logic out_load;
  } pipe_ctrl_t;

  typedef struct packed {
    logic signed [9:0]  holding;
    logic signed [32:0] product;
    logic               adapted;
  } mid_t;

endpackage

`default_nettype wire

// ===== design/adaptive_hold_power_lift_control_core.sv =====
// adaptive holding power lift controller
// input channel (in_valid/in_ready): one beat carries op, target, position
//   and now_ms; op 0 loads a new target and clears the last-run time and
//   gives no result, op 1 is a position sample and gives one result beat
// output channel (out_valid/out_ready): drive_power, holding_power, adapted
// apb port: eight registers at byte addresses 0x00 to 0x1c, pready tied
//   high; any write re-initialises holding, neutral and the in-band flag
//   on the following cycle
// pipeline: input register, adaptation and multiply stage, add and saturate
//   stage; throughput is one beat per cycle while the output is not stalled,
//   set by the adaptation loop on the holding state in the middle stage
// stall: the output stage holds while out_valid is high and out_ready is
//   low, and each earlier stage holds only once the stage after it is full;
//   in_ready drops once every stage is full, so no beat is lost
// reset: rst is synchronous and active high, it empties the pipeline and
//   loads the register defaults and the zero state
`default_nettype none

module adaptive_hold_power_lift_control_core #(
  parameter int unsigned REFRESH_MS = ahplc_pkg::REFRESH_MS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // apb configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ahplc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [ahplc_pkg::CFG_DW-1:0] pwdata,
  output logic      [ahplc_pkg::CFG_DW-1:0] prdata,
  output logic                              pready,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         op,
  input  wire logic signed [15:0]           target,
  input  wire logic signed [15:0]           position,
  input  wire logic        [31:0]           now_ms,
  // output channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [23:0]                drive_power,
  output logic signed [9:0]                 holding_power,
  output logic                              adapted
);
  import ahplc_pkg::*;

  cfg_t       cfg;
  logic       reinit;
  pipe_ctrl_t ctrl;
  mid_t       mid;

  // stage valids
  logic s1_valid, mid_valid;
  logic s1_go, mid_go;

  // input register
  logic               s1_op;
  logic signed [15:0] s1_target;
  logic signed [15:0] s1_position;
  logic        [31:0] s1_now_ms;

  // a stage moves on when the one after it is empty or moving on
  assign mid_go   = !out_valid || out_ready;
  assign s1_go    = !mid_valid || mid_go;
  assign in_ready = !s1_valid || s1_go;

  assign ctrl.s1_fire  = s1_valid && s1_go;
  assign ctrl.mid_load = s1_valid && s1_go && s1_op;  // set target beats end here
  assign ctrl.out_load = mid_valid && mid_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      // middle stage fills whenever it is free, even under an output stall
      if (s1_go) begin
        mid_valid <= ctrl.mid_load;
      end
      if (mid_go) begin
        out_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op       <= op;
      s1_target   <= target;
      s1_position <= position;
      s1_now_ms   <= now_ms;
    end
  end

  ahplc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .reinit  (reinit)
  );

  // holding state, adaptation and the proportional product
  ahplc_adapt #(
    .REFRESH_MS (REFRESH_MS)
  ) u_adapt (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .reinit      (reinit),
    .ctrl        (ctrl),
    .s1_op       (s1_op),
    .s1_target   (s1_target),
    .s1_position (s1_position),
    .s1_now_ms   (s1_now_ms),
    .mid         (mid)
  );

  // holding plus product, truncation toward zero, saturation, result register
  ahplc_drive u_drive (
    .clk           (clk),
    .ctrl          (ctrl),
    .mid           (mid),
    .drive_power   (drive_power),
    .holding_power (holding_power),
    .adapted       (adapted)
  );

endmodule

`default_nettype wire

// ===== design/ahplc_cfg.sv =====
`default_nettype none

module ahplc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ahplc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [ahplc_pkg::CFG_DW-1:0] pwdata,
  output logic      [ahplc_pkg::CFG_DW-1:0] prdata,
  output logic                              pready,
  output ahplc_pkg::cfg_t                   cfg,
  output logic                              reinit
);
  import ahplc_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p          <= 16'sd0;
      cfg.neutral_initial <= 8'sd0;
      cfg.step_change     <= 7'd1;
      cfg.error_threshold <= 15'd0;
      cfg.upper_bound     <= 16'sh7FFF;
      cfg.lower_bound     <= 16'sh8000;
      cfg.max_speed       <= 15'd0;
      cfg.learn_enable    <= 1'b0;
      reinit              <= 1'b0;
    end else begin
      reinit <= wr;
      if (wr) begin
        unique case (idx)
          REG_GAIN_P:          cfg.gain_p          <= pwdata[15:0];
          REG_NEUTRAL_INITIAL: cfg.neutral_initial <= pwdata[7:0];
          REG_STEP_CHANGE:     cfg.step_change     <= pwdata[6:0];
          REG_ERROR_THRESHOLD: cfg.error_threshold <= pwdata[14:0];
          REG_UPPER_BOUND:     cfg.upper_bound     <= pwdata[15:0];
          REG_LOWER_BOUND:     cfg.lower_bound     <= pwdata[15:0];
          REG_MAX_SPEED:       cfg.max_speed       <= pwdata[14:0];
          REG_LEARN_ENABLE:    cfg.learn_enable    <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // read back, signed fields sign extended
  always_comb begin
    unique case (idx)
      REG_GAIN_P:          prdata = {{16{cfg.gain_p[15]}}, cfg.gain_p};
      REG_NEUTRAL_INITIAL: prdata = {{24{cfg.neutral_initial[7]}}, cfg.neutral_initial};
      REG_STEP_CHANGE:     prdata = {25'd0, cfg.step_change};
      REG_ERROR_THRESHOLD: prdata = {17'd0, cfg.error_threshold};
      REG_UPPER_BOUND:     prdata = {{16{cfg.upper_bound[15]}}, cfg.upper_bound};
      REG_LOWER_BOUND:     prdata = {{16{cfg.lower_bound[15]}}, cfg.lower_bound};
      REG_MAX_SPEED:       prdata = {17'd0, cfg.max_speed};
      REG_LEARN_ENABLE:    prdata = {31'd0, cfg.learn_enable};
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ahplc_adapt.sv =====
`default_nettype none

module ahplc_adapt #(
  parameter int unsigned REFRESH_MS = ahplc_pkg::REFRESH_MS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ahplc_pkg::cfg_t       cfg,
  input  wire logic                  reinit,
  input  wire ahplc_pkg::pipe_ctrl_t ctrl,
  input  wire logic                  s1_op,
  input  wire logic signed [15:0]    s1_target,
  input  wire logic signed [15:0]    s1_position,
  input  wire logic        [31:0]    s1_now_ms,
  output ahplc_pkg::mid_t            mid
);
  import ahplc_pkg::*;

  logic signed [9:0]  holding;
  logic signed [8:0]  neutral;
  logic               was_in_band;
  logic signed [15:0] previous_position;
  logic signed [15:0] target_position;
  logic        [31:0] last_run_ms;

  logic               elapsed;
  logic signed [17:0] pos_x, tgt_hi, tgt_lo, low_hi, up_lo, thr_x;
  logic               want_down, want_up, in_band;
  logic signed [16:0] delta, diff;
  logic        [15:0] speed, ms_x, ms_half;
  logic signed [10:0] hold_x, step_x, hold_adj;
  logic signed [9:0]  neutral_x, neutral_next;
  logic signed [9:0]  holding_next;
  logic               was_in_band_next;
  logic               leave, dir_up;

  assign elapsed = (s1_now_ms - last_run_ms) > 32'(REFRESH_MS);

  assign pos_x  = {{2{s1_position[15]}}, s1_position};
  assign thr_x  = {3'b000, cfg.error_threshold};
  assign tgt_hi = {{2{target_position[15]}}, target_position} + thr_x;
  assign tgt_lo = {{2{target_position[15]}}, target_position} - thr_x;
  assign low_hi = {{2{cfg.lower_bound[15]}}, cfg.lower_bound} + thr_x;
  assign up_lo  = {{2{cfg.upper_bound[15]}}, cfg.upper_bound} - thr_x;

  assign want_down = (pos_x > tgt_hi) && (pos_x > low_hi);
  assign want_up   = (pos_x < tgt_lo) && (pos_x < up_lo);
  assign in_band   = (pos_x < tgt_hi) && (pos_x > tgt_lo);

  assign delta   = {s1_position[15], s1_position}
                 - {previous_position[15], previous_position};
  assign speed   = delta[16] ? 16'(-delta) : delta[15:0];
  assign ms_x    = {1'b0, cfg.max_speed};
  assign ms_half = {2'b00, cfg.max_speed[14:1]};

  assign hold_x    = {holding[9], holding};
  assign step_x    = {4'd0, cfg.step_change};
  assign neutral_x = {neutral[8], neutral};

  always_comb begin
    hold_adj         = hold_x;
    was_in_band_next = was_in_band;
    neutral_next     = neutral_x;
    leave            = 1'b0;
    dir_up           = 1'b0;
    if (want_down && (holding > HOLD_ADAPT_MIN)) begin
      if (s1_position >= previous_position) begin
        hold_adj = hold_x - step_x;
      end else if (speed > ms_x) begin
        hold_adj = hold_x + step_x;
      end else if (speed < ms_half) begin
        hold_adj = hold_x - step_x;
      end
      leave = 1'b1;
    end else if (want_up && (holding < HOLD_ADAPT_MAX)) begin
      if (s1_position <= previous_position) begin
        hold_adj = hold_x + step_x;
      end else if (speed > ms_x) begin
        hold_adj = hold_x - step_x;
      end else if (speed < ms_half) begin
        hold_adj = hold_x + step_x;
      end
      leave  = 1'b1;
      dir_up = 1'b1;
    end else if (in_band) begin
      hold_adj         = {{2{neutral[8]}}, neutral};
      was_in_band_next = 1'b1;
    end
    // leaving the band nudges neutral toward the direction of travel when learning is enabled
    if (leave && was_in_band) begin
      was_in_band_next = 1'b0;
      if (cfg.learn_enable) begin
        if (!dir_up && (neutral > NEUTRAL_MIN)) begin
          neutral_next = neutral_x - {3'd0, cfg.step_change};
        end else if (dir_up && (neutral < NEUTRAL_MAX)) begin
          neutral_next = neutral_x + {3'd0, cfg.step_change};
        end
      end
    end
    if (hold_adj > HOLD_SAT_MAX) begin
      holding_next = HOLD_SAT_MAX[9:0];
    end else if (hold_adj < HOLD_SAT_MIN) begin
      holding_next = HOLD_SAT_MIN[9:0];
    end else begin
      holding_next = hold_adj[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding           <= 10'sd0;
      neutral           <= 9'sd0;
      was_in_band       <= 1'b0;
      previous_position <= 16'sd0;
      target_position   <= 16'sd0;
      last_run_ms       <= 32'd0;
    end else begin
      if (ctrl.s1_fire) begin
        if (!s1_op) begin
          target_position <= s1_target;
          last_run_ms     <= 32'd0;
        end else if (elapsed) begin
          last_run_ms       <= s1_now_ms;
          previous_position <= s1_position;
          holding           <= holding_next;
          neutral           <= neutral_next[8:0];
          was_in_band       <= was_in_band_next;
        end
      end
      if (reinit) begin
        holding     <= 10'sd0;
        neutral     <= {cfg.neutral_initial[7], cfg.neutral_initial};
        was_in_band <= 1'b0;
      end
    end
  end

  assign diff = {target_position[15], target_position} - {s1_position[15], s1_position};

  always_ff @(posedge clk) begin
    if (ctrl.mid_load) begin
      mid.holding <= elapsed ? holding_next : holding;
      mid.product <= diff * cfg.gain_p;
      mid.adapted <= elapsed;
    end
  end

`ifndef SYNTHESIS
  a_holding_range: assert property (@(posedge clk) disable iff (rst)
    (holding >= -10'sd511) && (holding <= 10'sd511))
    else $error("holding out of range");

  a_neutral_range: assert property (@(posedge clk) disable iff (rst)
    (neutral >= -9'sd253) && (neutral <= 9'sd253))
    else $error("neutral out of range");

  a_reinit_clears: assert property (@(posedge clk) disable iff (rst)
    reinit |=> (holding == 10'sd0) && !was_in_band)
    else $error("reinit did not clear holding");

  a_target_clears_run: assert property (@(posedge clk) disable iff (rst)
    (ctrl.s1_fire && !s1_op) |=> (last_run_ms == 32'd0))
    else $error("set target did not clear last run time");

  a_idle_keeps_holding: assert property (@(posedge clk) disable iff (rst)
    (ctrl.s1_fire && s1_op && !elapsed && !reinit) |=> $stable(holding))
    else $error("holding changed without adaptation");
`endif

endmodule

`default_nettype wire

// ===== design/ahplc_drive.sv =====
`default_nettype none

module ahplc_drive (
  input  wire logic                  clk,
  input  wire ahplc_pkg::pipe_ctrl_t ctrl,
  input  wire ahplc_pkg::mid_t       mid,
  output logic signed [23:0]         drive_power,
  output logic signed [9:0]          holding_power,
  output logic                       adapted
);
  import ahplc_pkg::*;

  logic signed [33:0] num;
  logic signed [25:0] quot;
  logic signed [23:0] drive_sat;

  assign num  = {{16{mid.holding[9]}}, mid.holding, 8'd0}
              + {mid.product[32], mid.product};
  // arithmetic shift floors, bump negatives with a remainder toward zero
  assign quot = num[33:8] + {25'd0, (num[33] && (num[7:0] != 8'd0))};

  always_comb begin
    if ((quot[25:23] == 3'b000) || (quot[25:23] == 3'b111)) begin
      drive_sat = quot[23:0];
    end else if (quot[25]) begin
      drive_sat = 24'sh800000;
    end else begin
      drive_sat = 24'sh7FFFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      drive_power   <= drive_sat;
      holding_power <= mid.holding;
      adapted       <= mid.adapted;
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ahplc_pkg::*;

  // input beat operations
  localparam logic OP_SET_TARGET = 1'b0;
  localparam logic OP_SAMPLE     = 1'b1;

  // holding only adapts inside this magnitude, and saturates at the clamp
  localparam int ADAPT_LIMIT = 127;
  localparam int HOLD_CLAMP  = 511;
  localparam longint DRIVE_MAX = 64'sd8388607;
  localparam longint DRIVE_MIN = -64'sd8388608;

  // cycles with no beat, no apb access, before the run is declared hung
  localparam int QUIET_LIMIT = 3000;
  // op 0 beats leave nothing behind, so allow the pipe to empty
  localparam int PIPE_DRAIN  = 6;

  typedef struct packed {
    logic signed [23:0] drive_power;
    logic signed [9:0]  holding_power;
    logic               adapted;
  } drive_beat_t;

  // predicts the controller and holds the drive beats still owed
  class drive_scoreboard;
    cfg_t               regs;
    logic signed [9:0]  holding;
    logic signed [8:0]  neutral;
    bit                 in_band;
    logic signed [15:0] prev_pos;
    logic signed [15:0] target_pos;
    logic        [31:0] last_run_ms;
    drive_beat_t        due[$];
    int                 fails;

    function new();
      regs.gain_p          = '0;
      regs.neutral_initial = '0;
      regs.step_change     = 7'd1;
      regs.error_threshold = '0;
      regs.upper_bound     = 16'sh7fff;
      regs.lower_bound     = 16'sh8000;
      regs.max_speed       = '0;
      regs.learn_enable    = 1'b0;
      prev_pos    = '0;
      target_pos  = '0;
      last_run_ms = '0;
      fails       = 0;
      reinit();
    endfunction

    function void reinit();
      holding = '0;
      neutral = {regs.neutral_initial[7], regs.neutral_initial};
      in_band = 1'b0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_GAIN_P:          regs.gain_p          = v[15:0];
        REG_NEUTRAL_INITIAL: regs.neutral_initial = v[7:0];
        REG_STEP_CHANGE:     regs.step_change     = v[6:0];
        REG_ERROR_THRESHOLD: regs.error_threshold = v[14:0];
        REG_UPPER_BOUND:     regs.upper_bound     = v[15:0];
        REG_LOWER_BOUND:     regs.lower_bound     = v[15:0];
        REG_MAX_SPEED:       regs.max_speed       = v[14:0];
        REG_LEARN_ENABLE:    regs.learn_enable    = v[0];
        default: ;
      endcase
      reinit();
    endfunction

    // leaving the band may nudge the learned neutral towards the exit side
    function void leave_band(int dir);
      int n;
      int step_sz;
      if (!in_band) return;
      in_band = 1'b0;
      if (!regs.learn_enable) return;
      n = neutral;
      step_sz = regs.step_change;
      if (dir < 0 && n > -ADAPT_LIMIT) n -= step_sz;
      else if (dir > 0 && n < ADAPT_LIMIT) n += step_sz;
      neutral = 9'(n);
    endfunction

    function void adapt_holding(int p);
      int h, thr, tgt, prv, speed, lim_lo, lim_hi, top_speed, step_sz;
      bit want_down, want_up;
      h         = holding;
      thr       = regs.error_threshold;
      tgt       = target_pos;
      prv       = prev_pos;
      lim_lo    = int'($signed(regs.lower_bound));
      lim_hi    = int'($signed(regs.upper_bound));
      top_speed = regs.max_speed;
      step_sz   = regs.step_change;
      speed     = (p > prv) ? p - prv : prv - p;
      want_down = (p > tgt + thr) && (p > lim_lo + thr);
      want_up   = (p < tgt - thr) && (p < lim_hi - thr);
      if (want_down && h > -ADAPT_LIMIT) begin
        if (p >= prv) h -= step_sz;
        else if (speed > top_speed) h += step_sz;
        else if (speed < top_speed / 2) h -= step_sz;
        leave_band(-1);
      end else if (want_up && h < ADAPT_LIMIT) begin
        if (p <= prv) h += step_sz;
        else if (speed > top_speed) h -= step_sz;
        else if (speed < top_speed / 2) h += step_sz;
        leave_band(1);
      end else if (p < tgt + thr && p > tgt - thr) begin
        h = neutral;
        in_band = 1'b1;
      end
      if (h > HOLD_CLAMP) h = HOLD_CLAMP;
      if (h < -HOLD_CLAMP) h = -HOLD_CLAMP;
      holding  = 10'(h);
      prev_pos = 16'(p);
    endfunction

    function void note_beat(logic o, logic [15:0] tgt, logic [15:0] pos, logic [31:0] now);
      drive_beat_t exp_beat;
      logic [31:0] gap;
      longint num, drv;
      if (o == OP_SET_TARGET) begin
        target_pos  = tgt;
        last_run_ms = '0;
        return;
      end
      gap = now - last_run_ms;
      exp_beat.adapted = 1'b0;
      if (gap > 32'(REFRESH_MS_DEFAULT)) begin
        last_run_ms = now;
        adapt_holding(int'($signed(pos)));
        exp_beat.adapted = 1'b1;
      end
      num = longint'(holding) * 256
          + (longint'(target_pos) - longint'($signed(pos))) * longint'($signed(regs.gain_p));
      drv = num / 256;
      if (drv > DRIVE_MAX) drv = DRIVE_MAX;
      if (drv < DRIVE_MIN) drv = DRIVE_MIN;
      exp_beat.drive_power   = 24'(drv);
      exp_beat.holding_power = holding;
      due.push_back(exp_beat);
    endfunction

    function void check_drive(drive_beat_t got);
      drive_beat_t want;
      if (due.size() == 0) begin
        $error("drive beat with nothing owed: drive_power %0d", $signed(got.drive_power));
        fails++;
        return;
      end
      want = due.pop_front();
      if (got.drive_power !== want.drive_power) begin
        $error("drive_power: expected %0d, got %0d",
               $signed(want.drive_power), $signed(got.drive_power));
        fails++;
      end
      if (got.holding_power !== want.holding_power) begin
        $error("holding_power: expected %0d, got %0d",
               $signed(want.holding_power), $signed(got.holding_power));
        fails++;
      end
      if (got.adapted !== want.adapted) begin
        $error("adapted: expected %0b, got %0b", want.adapted, got.adapted);
        fails++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_AW-1:0]        paddr = '0;
  logic [CFG_DW-1:0]        pwdata = '0;
  logic [CFG_DW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     op = 1'b0;
  logic signed [15:0]       target = '0;
  logic signed [15:0]       position = '0;
  logic        [31:0]       now_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [23:0]       drive_power;
  logic signed [9:0]        holding_power;
  logic                     adapted;

  drive_scoreboard sb = new();

  // idling odds in percent, set per phase
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  adaptive_hold_power_lift_control_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .target        (target),
    .position      (position),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_power   (drive_power),
    .holding_power (holding_power),
    .adapted       (adapted)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: check each accepted beat, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_drive(drive_beat_t'{drive_power, holding_power, adapted});
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // hang guard: nothing moving on either channel or the apb port
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // one input beat; called just after an edge, returns just after acceptance
  task automatic send_beat(logic o, logic [15:0] tgt, logic [15:0] pos, logic [31:0] now);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    target   <= tgt;
    position <= pos;
    now_ms   <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(o, tgt, pos, now);
  endtask

  // setup then access; the register takes the value at the access edge
  task automatic apb_write(reg_idx_t idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic load_config(cfg_t c);
    apb_write(REG_GAIN_P,          {16'd0, c.gain_p});
    apb_write(REG_NEUTRAL_INITIAL, {24'd0, c.neutral_initial});
    apb_write(REG_STEP_CHANGE,     {25'd0, c.step_change});
    apb_write(REG_ERROR_THRESHOLD, {17'd0, c.error_threshold});
    apb_write(REG_UPPER_BOUND,     {16'd0, c.upper_bound});
    apb_write(REG_LOWER_BOUND,     {16'd0, c.lower_bound});
    apb_write(REG_MAX_SPEED,       {17'd0, c.max_speed});
    apb_write(REG_LEARN_ENABLE,    {31'd0, c.learn_enable});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // block idle: every owed beat back, then a pause for trailing op 0 beats
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // mostly modest gains and bands so that drive is not always pinned
  function automatic cfg_t random_cfg();
    cfg_t c;
    c.gain_p          = ($urandom_range(3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 2048) - 1024);
    c.neutral_initial = 8'($urandom_range(0, 254) - 127);
    c.step_change     = $urandom_range(1) ? 7'($urandom_range(0, 8))
                                          : 7'($urandom_range(0, 127));
    c.error_threshold = ($urandom_range(4) == 0) ? 15'($urandom) : 15'($urandom_range(0, 150));
    c.upper_bound     = $urandom_range(1) ? 16'h7fff : 16'($urandom_range(0, 30000));
    c.lower_bound     = $urandom_range(1) ? 16'h8000 : 16'(0 - $urandom_range(0, 30000));
    c.max_speed       = ($urandom_range(4) == 0) ? 15'($urandom) : 15'($urandom_range(0, 300));
    c.learn_enable    = 1'($urandom_range(1));
    return c;
  endfunction

  // hand-picked beats: timing edges, every branch of the adaptation,
  // learning on both exits, field extremes and drive saturation
  task automatic run_directed();
    send_beat(OP_SET_TARGET, 16'sd0, 16'h7fff, 32'hffff_ffff);
    send_beat(OP_SAMPLE, 16'h8000, 16'sd5, 32'd0);        // no time elapsed
    send_beat(OP_SAMPLE, 16'h7fff, 16'sd5, 32'd20);       // exactly one interval, still held
    send_beat(OP_SAMPLE, 16'sd0, 16'sd5, 32'd21);         // in band, neutral taken
    send_beat(OP_SAMPLE, 16'sd0, 16'sd300, 32'd50);       // above, not falling
    send_beat(OP_SAMPLE, 16'sd0, 16'sd200, 32'd80);       // falling too fast
    send_beat(OP_SAMPLE, 16'sd0, 16'sd190, 32'd110);      // falling too slowly
    send_beat(OP_SAMPLE, 16'sd0, 16'sd165, 32'd140);      // speed within window
    send_beat(OP_SAMPLE, 16'sd0, -16'sd300, 32'd170);     // below, not rising
    send_beat(OP_SAMPLE, 16'sd0, -16'sd100, 32'd200);     // rising too fast
    send_beat(OP_SAMPLE, 16'sd0, -16'sd95, 32'd230);      // rising too slowly
    send_beat(OP_SAMPLE, 16'sd0, 16'sd0, 32'd260);        // back in band
    send_beat(OP_SAMPLE, 16'sd0, -16'sd300, 32'd290);     // upward exit, learns
    send_beat(OP_SET_TARGET, 16'h8000, 16'h8000, 32'd0);
    send_beat(OP_SAMPLE, 16'h7fff, 16'h7fff, 32'hffff_ffff);
    send_beat(OP_SET_TARGET, 16'h7fff, 16'h7fff, 32'hffff_ffff);
    send_beat(OP_SAMPLE, 16'h8000, 16'h8000, 32'h8000_0000);
    send_beat(OP_SAMPLE, 16'h8000, 16'h8000, 32'h8000_0014);
    send_beat(OP_SAMPLE, 16'h1234, 16'h7fff, 32'h8000_0015);
    // fast descent keeps adding step until holding saturates
    send_beat(OP_SET_TARGET, 16'sd0, 16'sd0, 32'd0);
    send_beat(OP_SAMPLE, 16'sd0, 16'sd30000, 32'd21);
    send_beat(OP_SAMPLE, 16'sd0, 16'sd20000, 32'd50);
    send_beat(OP_SAMPLE, 16'sd0, 16'sd10000, 32'd80);
    send_beat(OP_SAMPLE, 16'sd0, 16'sd5000, 32'd110);
    send_beat(OP_SAMPLE, 16'sd0, 16'sd2000, 32'd140);
  endtask

  // runs of samples: a target, then a lift drifting towards it with jitter
  // and a clock that sometimes passes the refresh interval; a little noise
  task automatic run_walk(int n);
    int tgt, pos, span;
    int unsigned pick;
    logic [31:0] clock_ms;
    tgt = 0;
    pos = 0;
    clock_ms = '0;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      span = int'(sb.regs.error_threshold) + int'(sb.regs.max_speed);
      if (span > 4000) span = 4000;
      span += 8;
      if (i == 0 || pick < 8) begin
        // new target, often close to a travel limit
        case ($urandom_range(2))
          0: tgt = int'($signed(16'($urandom)));
          1: tgt = int'($signed(sb.regs.lower_bound)) + int'($urandom_range(0, 2 * span)) - span;
          default: tgt = int'($signed(sb.regs.upper_bound)) + int'($urandom_range(0, 2 * span))
                         - span;
        endcase
        tgt = clamp16(tgt);
        pos = clamp16(tgt + int'($urandom_range(0, 8 * span)) - 4 * span);
        clock_ms = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 30);
        send_beat(OP_SET_TARGET, 16'(tgt), 16'($urandom), $urandom);
      end else if (pick < 92) begin
        clock_ms += $urandom_range(0, 35);
        pos = clamp16(pos + (tgt - pos) / 4 + int'($urandom_range(0, 2 * span)) - span);
        send_beat(OP_SAMPLE, 16'($urandom), 16'(pos), clock_ms);
      end else begin
        send_beat(1'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset values first: zero gain and an empty dead band
    run_walk(40);

    for (int p = 1; p < 10; p++) begin
      settle();
      // rotate idling: none, sender gaps, receiver stalls, both
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      case (p)
        1: load_config(cfg_t'{16'sh7fff, 8'sd100, 7'd127, 15'd10,
                              16'sh7fff, 16'sh8000, 15'd40, 1'b1});
        2: load_config(cfg_t'{16'sh7fff, 8'sd127, 7'd127, 15'h7fff,
                              16'sh7fff, 16'sh7fff, 15'h7fff, 1'b1});
        3: load_config(cfg_t'{16'sh8000, -8'sd127, 7'd0, 15'd0,
                              16'sh8000, 16'sh8000, 15'd0, 1'b0});
        default: load_config(random_cfg());
      endcase
      if (p == 1) run_directed();
      else run_walk(45);
    end

    // drain, then allow the pipe latency before the verdict
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (sb.fails == 0 && sb.due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
